[hdl/cpt_pkg.sv]
package cpt_pkg;

    // Default sizing
    localparam int MAX_VERTICES_DEF = 16;
    localparam int COORD_BITS_DEF   = 16;

    // Request codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Query sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } state_t;

    // Tag that travels with each vertex read through the edge pipeline
    typedef struct packed {
        logic vld;      // a vertex is present
        logic prime;    // first read of a walk: only loads the previous vertex
        logic is_ref;   // closing edge, sets the reference orientation
        logic is_last;  // final edge of the walk
    } edge_tag_t;

endpackage

[hdl/cpt_ram.sv]
module cpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/cpt_edge.sv]
module cpt_edge #(
    parameter int COORD_BITS = cpt_pkg::COORD_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        kill,
    input  cpt_pkg::edge_tag_t          in_tag,
    input  logic [2*COORD_BITS-1:0]     vertex,
    input  logic signed [COORD_BITS-1:0] px,
    input  logic signed [COORD_BITS-1:0] py,
    output cpt_pkg::edge_tag_t          out_tag,
    output logic signed [2*COORD_BITS+1:0] prod_a,
    output logic signed [2*COORD_BITS+1:0] prod_b,
    output logic signed [COORD_BITS:0]  cx,
    output logic signed [COORD_BITS:0]  cy,
    output logic signed [COORD_BITS:0]  ex,
    output logic signed [COORD_BITS:0]  ey
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * COORD_BITS + 2;

    logic signed [COORD_BITS-1:0] ax_reg;
    logic signed [COORD_BITS-1:0] ay_reg;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic signed [DW-1:0]         dax;
    logic signed [DW-1:0]         day;
    logic signed [DW-1:0]         dbx;
    logic signed [DW-1:0]         dby;
    logic signed [DW-1:0]         edx;
    logic signed [DW-1:0]         edy;
    logic signed [PW-1:0]         pa;
    logic signed [PW-1:0]         pb;
    cpt_pkg::edge_tag_t           tag_reg;
    cpt_pkg::edge_tag_t           tag_next;
    logic signed [PW-1:0]         pa_reg;
    logic signed [PW-1:0]         pb_reg;
    logic signed [DW-1:0]         cx_reg;
    logic signed [DW-1:0]         cy_reg;
    logic signed [DW-1:0]         ex_reg;
    logic signed [DW-1:0]         ey_reg;

    assign bx = signed'(vertex[2*COORD_BITS-1:COORD_BITS]);
    assign by = signed'(vertex[COORD_BITS-1:0]);

    // Offsets from the query point and the edge vector
    assign dax = DW'(ax_reg) - DW'(px);
    assign day = DW'(ay_reg) - DW'(py);
    assign dbx = DW'(bx) - DW'(px);
    assign dby = DW'(by) - DW'(py);
    assign edx = DW'(ax_reg) - DW'(bx);
    assign edy = DW'(ay_reg) - DW'(by);

    // Two cross product terms in parallel
    assign pa = PW'(dax) * PW'(dby);
    assign pb = PW'(day) * PW'(dbx);

    // Advance the previous vertex on every returned read
    always_ff @(posedge clk)
    begin
        if (in_tag.vld)
        begin
            ax_reg <= bx;
            ay_reg <= by;
        end
    end

    // Forward an edge only when both of its vertices are known and no kill is raised
    always_comb
    begin
        tag_next         = in_tag;
        tag_next.prime   = 1'b0;
        tag_next.vld     = in_tag.vld && !in_tag.prime && !kill;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= tag_next;
        end
    end

    // Hold products and offsets for the decision stage
    always_ff @(posedge clk)
    begin
        pa_reg <= pa;
        pb_reg <= pb;
        cx_reg <= dax;
        cy_reg <= day;
        ex_reg <= edx;
        ey_reg <= edy;
    end

    assign out_tag = tag_reg;
    assign prod_a  = pa_reg;
    assign prod_b  = pb_reg;
    assign cx      = cx_reg;
    assign cy      = cy_reg;
    assign ex      = ex_reg;
    assign ey      = ey_reg;

endmodule

[hdl/convex_polygon_point_test.sv]
// Point-in-convex-polygon test.
// Command channel: an item transfers at a rising edge with start high and
// busy low. req_type selects a vertex load or a point query; coord_x and
// coord_y carry the point, first_vertex restarts the list on a load.
// A load is written into the vertex RAM in the transfer cycle and gives no
// result; busy stays low, so the next item may follow at once.
// A query with fewer than three stored vertices answers on the next cycle
// with too_few_vertices set. Otherwise the sequencer reads one vertex per
// cycle from the RAM (last vertex, then vertex 0 up to the last) and the
// edge pipeline evaluates one cross product per cycle. The walk stops at
// the first deciding edge; done is registered from that decision, and busy
// stays high through the walk and drops as done rises.
// The result shows on inside_res and too_few_vertices for one cycle with
// done high; the receiver cannot stall, so nothing is held back.
// Reset clears the vertex count and the sequencer; RAM contents are not
// cleared, and only entries below the count are ever read.
module convex_polygon_point_test #(
    parameter int MAX_VERTICES = cpt_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = cpt_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         req_type,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    input  logic                         first_vertex,
    output logic                         done,
    output logic                         inside_res,
    output logic                         too_few_vertices
);

    localparam int AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int RC_W  = $clog2(MAX_VERTICES + 2);
    localparam int DW    = COORD_BITS + 1;
    localparam int PW    = 2 * COORD_BITS + 2;

    cpt_pkg::state_t              state_reg;
    cpt_pkg::state_t              state_next;
    logic [CNT_W-1:0]             vcount_reg;
    logic [CNT_W-1:0]             vcount_next;
    logic [CNT_W-1:0]             qcnt_reg;
    logic [CNT_W-1:0]             qcnt_next;
    logic [RC_W-1:0]              rd_cnt_reg;
    logic [RC_W-1:0]              rd_cnt_next;
    cpt_pkg::edge_tag_t           tag_reg;
    cpt_pkg::edge_tag_t           tag_next;
    logic                         ref_pos_reg;
    logic                         ref_pos_next;
    logic                         done_reg;
    logic                         done_next;
    logic                         inside_reg;
    logic                         inside_next;
    logic                         few_reg;
    logic                         few_next;
    logic signed [COORD_BITS-1:0] px_reg;
    logic signed [COORD_BITS-1:0] py_reg;

    logic                         xfer;
    logic [CNT_W-1:0]             base;
    logic                         wr_en;
    logic [2*COORD_BITS-1:0]      wr_data;
    logic [RC_W-1:0]              rd_sel;
    logic [AW-1:0]                rd_addr;
    logic [2*COORD_BITS-1:0]      rd_data;
    logic                         issue;

    cpt_pkg::edge_tag_t           e_tag;
    logic signed [PW-1:0]         prod_a;
    logic signed [PW-1:0]         prod_b;
    logic signed [DW-1:0]         cx;
    logic signed [DW-1:0]         cy;
    logic signed [DW-1:0]         ex;
    logic signed [DW-1:0]         ey;
    logic                         c_zero;
    logic                         c_pos;
    logic signed [DW-1:0]         off;
    logic signed [DW-1:0]         span;
    logic                         ratio_ok;
    logic                         on_seg;
    logic                         finish;
    logic                         fin_val;

    assign busy    = (state_reg == cpt_pkg::ST_WALK);
    assign xfer    = start && !busy;
    assign base    = first_vertex ? '0 : vcount_reg;
    assign wr_en   = xfer && (req_type == cpt_pkg::REQ_LOAD)
                     && (base < CNT_W'(MAX_VERTICES));
    assign wr_data = {coord_x, coord_y};

    // Read order: last vertex first, then vertex 0 onward
    assign rd_sel  = (rd_cnt_reg == '0) ? (RC_W'(qcnt_reg) - RC_W'(1))
                                        : (rd_cnt_reg - RC_W'(1));
    assign rd_addr = rd_sel[AW-1:0];

    cpt_ram #(
        .WIDTH (2 * COORD_BITS),
        .DEPTH (MAX_VERTICES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (base[AW-1:0]),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    cpt_edge #(
        .COORD_BITS (COORD_BITS)
    ) u_edge (
        .clk     (clk),
        .rst_n   (rst_n),
        .kill    (finish),
        .in_tag  (tag_reg),
        .vertex  (rd_data),
        .px      (px_reg),
        .py      (py_reg),
        .out_tag (e_tag),
        .prod_a  (prod_a),
        .prod_b  (prod_b),
        .cx      (cx),
        .cy      (cy),
        .ex      (ex),
        .ey      (ey)
    );

    // Orientation sign of the current edge
    assign c_zero = (prod_a == prod_b);
    assign c_pos  = (prod_a > prod_b);

    // Collinear case: check the offset lies within the edge span
    assign off  = (cx != '0) ? cx : cy;
    assign span = (cx != '0) ? ex : ey;

    always_comb
    begin
        if (span > 0)
        begin
            ratio_ok = (off >= 0) && (off <= span);
        end
        else if (span < 0)
        begin
            ratio_ok = (off <= 0) && (off >= span);
        end
        else
        begin
            ratio_ok = 1'b0;
        end
    end

    assign on_seg = ((cx == '0) && (cy == '0)) || ratio_ok;

    // Decide on the edge leaving the pipeline
    always_comb
    begin
        finish  = 1'b0;
        fin_val = 1'b0;
        if (e_tag.vld)
        begin
            if (c_zero)
            begin
                finish  = 1'b1;
                fin_val = on_seg;
            end
            else if (!e_tag.is_ref && (c_pos != ref_pos_reg))
            begin
                finish  = 1'b1;
                fin_val = 1'b0;
            end
            else if (e_tag.is_last)
            begin
                finish  = 1'b1;
                fin_val = 1'b1;
            end
        end
    end

    assign issue = (state_reg == cpt_pkg::ST_WALK) && !finish
                   && (rd_cnt_reg <= RC_W'(qcnt_reg));

    // Sequencer next state
    always_comb
    begin
        state_next   = state_reg;
        vcount_next  = vcount_reg;
        qcnt_next    = qcnt_reg;
        rd_cnt_next  = rd_cnt_reg;
        ref_pos_next = ref_pos_reg;
        done_next    = 1'b0;
        inside_next  = inside_reg;
        few_next     = few_reg;
        tag_next     = '0;

        unique case (state_reg)
            cpt_pkg::ST_IDLE:
            begin
                if (xfer)
                begin
                    if (req_type == cpt_pkg::REQ_LOAD)
                    begin
                        if (wr_en)
                        begin
                            vcount_next = base + CNT_W'(1);
                        end
                    end
                    else if (vcount_reg < CNT_W'(3))
                    begin
                        done_next   = 1'b1;
                        inside_next = 1'b0;
                        few_next    = 1'b1;
                    end
                    else
                    begin
                        state_next  = cpt_pkg::ST_WALK;
                        qcnt_next   = vcount_reg;
                        rd_cnt_next = '0;
                    end
                end
            end
            cpt_pkg::ST_WALK:
            begin
                if (issue)
                begin
                    tag_next.vld     = 1'b1;
                    tag_next.prime   = (rd_cnt_reg == '0);
                    tag_next.is_ref  = (rd_cnt_reg == RC_W'(1));
                    tag_next.is_last = (rd_cnt_reg == RC_W'(qcnt_reg));
                    rd_cnt_next      = rd_cnt_reg + RC_W'(1);
                end
                if (e_tag.vld && e_tag.is_ref)
                begin
                    ref_pos_next = c_pos;
                end
                if (finish)
                begin
                    state_next  = cpt_pkg::ST_IDLE;
                    done_next   = 1'b1;
                    inside_next = fin_val;
                    few_next    = 1'b0;
                end
            end
            default:
            begin
                state_next = cpt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= cpt_pkg::ST_IDLE;
            vcount_reg  <= '0;
            qcnt_reg    <= '0;
            rd_cnt_reg  <= '0;
            tag_reg     <= '0;
            ref_pos_reg <= 1'b0;
            done_reg    <= 1'b0;
            inside_reg  <= 1'b0;
            few_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            vcount_reg  <= vcount_next;
            qcnt_reg    <= qcnt_next;
            rd_cnt_reg  <= rd_cnt_next;
            tag_reg     <= tag_next;
            ref_pos_reg <= ref_pos_next;
            done_reg    <= done_next;
            inside_reg  <= inside_next;
            few_reg     <= few_next;
        end
    end

    // Latch the query point on transfer
    always_ff @(posedge clk)
    begin
        if (xfer && (req_type == cpt_pkg::REQ_QUERY))
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
        end
    end

    assign done             = done_reg;
    assign inside_res       = inside_reg;
    assign too_few_vertices = few_reg;

`ifndef SYNTHESIS
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result raised while a walk is still running");

    a_few_outside: assert property (@(posedge clk) disable iff (!rst_n)
        (done && too_few_vertices) |-> !inside_res)
        else $error("short polygon reported as inside");

    a_short_query: assert property (@(posedge clk) disable iff (!rst_n)
        (xfer && (req_type == cpt_pkg::REQ_QUERY) && (vcount_reg < CNT_W'(3)))
        |=> (done && too_few_vertices))
        else $error("short polygon query did not answer next cycle");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        vcount_reg <= CNT_W'(MAX_VERTICES))
        else $error("vertex count past capacity");

    a_edge_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        e_tag.vld |-> (state_reg == cpt_pkg::ST_WALK))
        else $error("edge in flight outside a walk");
`endif

endmodule
